### rtl/comd_pkg.sv
// ----------------------------------------------------------------------------
// comd_pkg
// Shared types, constants and the arctangent table for the corridor
// nearest-obstacle block.
// ----------------------------------------------------------------------------
package comd_pkg;

    // default sizing
    localparam int COMD_CORDIC_STEPS = 16;
    localparam int COMD_RANGE_BITS   = 16;

    // field widths
    localparam int RANGE_IN_W  = 16;
    localparam int BEARING_W   = 17;
    localparam int WIDTH_W     = 16;
    localparam int OUT_W       = 21;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    // fixed-point constants, angles in q20 radians
    localparam int ZW            = 24;
    localparam int GAIN_W        = 20;
    localparam int ATAN_W        = 20;
    localparam int ATAN_IW       = 5;
    localparam int FRAC_BITS     = 20;
    localparam int BEARING_SHIFT = 6;

    localparam int FLAG_RANGE_MM  = 20;
    localparam int NONE_FOUND_MM  = 1000000;
    localparam int WIDTH_RESET_MM = 400;
    localparam int PI_Q20         = 3294199;
    localparam int HALF_PI_Q20    = 1647099;
    localparam int GAIN_Q20       = 636751;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load;
        logic rotate;
        logic update;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic flag;
        logic last;
        logic iter_done;
    } t_sts;

    // atan(2^-i) in q20, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q20(input logic [ATAN_IW-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/comd_ctrl.sv
// ----------------------------------------------------------------------------
// comd_ctrl
// Sequencer for one scan point: capture, load, cordic rotations, minimum
// update and result emission; owns the output valid flag.
// ----------------------------------------------------------------------------
module comd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  comd_pkg::t_sts i_sts,
    output comd_pkg::t_cmd o_cmd
);
    import comd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_ROT  = 5'b00100,
        S_UPD  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.flag) begin
                    n_state = i_sts.last ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.rotate = 1'b1;
                if (i_sts.iter_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid holds until the transaction completes
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/comd_dp.sv
// ----------------------------------------------------------------------------
// comd_dp
// Datapath: point registers, gain multiplier, iterative cordic rotator,
// corridor test, running minimum and output data register.
// ----------------------------------------------------------------------------
module comd_dp #(
    parameter int CORDIC_STEPS = comd_pkg::COMD_CORDIC_STEPS,
    parameter int RANGE_BITS   = comd_pkg::COMD_RANGE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  comd_pkg::t_cmd                 i_cmd,
    output comd_pkg::t_sts                 o_sts,
    input  logic [comd_pkg::RANGE_IN_W-1:0] i_range_mm,
    input  logic [comd_pkg::BEARING_W-1:0]  i_bearing,
    input  logic                           i_scan_last,
    input  logic                           i_cfg_we,
    input  logic [comd_pkg::WIDTH_W-1:0]    i_cfg_wdata,
    output logic [comd_pkg::OUT_W-1:0]      o_nearest_forward_mm
);
    import comd_pkg::*;

    // x and y are mm in q20 plus cordic growth and sign
    localparam int W      = RANGE_BITS + 23;
    localparam int CW     = W + 1;
    localparam int IW     = $clog2(CORDIC_STEPS);
    localparam int PROD_W = RANGE_BITS + GAIN_W;

    logic [RANGE_BITS-1:0]       r_range;
    logic signed [BEARING_W-1:0] r_bearing;
    logic                        r_last;
    logic signed [W-1:0]         r_x, r_y;
    logic signed [ZW-1:0]        r_z;
    logic [IW-1:0]               r_iter;
    logic [WIDTH_W-1:0]          r_width;
    logic signed [OUT_W-1:0]     r_min;
    logic [OUT_W-1:0]            r_out;

    // point capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_range   <= RANGE_BITS'(i_range_mm);
            r_bearing <= i_bearing;
            r_last    <= i_scan_last;
        end
    end

    assign o_sts.flag      = (r_range < RANGE_BITS'(FLAG_RANGE_MM));
    assign o_sts.last      = r_last;
    assign o_sts.iter_done = (r_iter == IW'(CORDIC_STEPS - 1));

    // angle reduction into the cordic range
    logic signed [ZW-1:0] z_in, z_red;
    logic                 flip;
    assign z_in = ZW'(r_bearing) <<< BEARING_SHIFT;
    always_comb begin
        if (z_in > ZW'(HALF_PI_Q20)) begin
            z_red = z_in - ZW'(PI_Q20);
            flip  = 1'b1;
        end else if (z_in < -ZW'(HALF_PI_Q20)) begin
            z_red = z_in + ZW'(PI_Q20);
            flip  = 1'b1;
        end else begin
            z_red = z_in;
            flip  = 1'b0;
        end
    end

    // start vector: range times inverse cordic gain
    logic [PROD_W-1:0]   prod;
    logic signed [W-1:0] x_start;
    assign prod    = r_range * GAIN_W'(GAIN_Q20);
    assign x_start = flip ? -signed'(W'(prod)) : signed'(W'(prod));

    // one micro-rotation
    logic signed [W-1:0]  dx, dy;
    logic signed [ZW-1:0] atan_z;
    assign dx     = r_y >>> r_iter;
    assign dy     = r_x >>> r_iter;
    assign atan_z = signed'(ZW'(atan_q20(ATAN_IW'(r_iter))));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= x_start;
            r_y <= '0;
            r_z <= z_red;
        end else if (i_cmd.rotate) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_z;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_z;
            end
        end
    end

    // rotation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_cmd.load) begin
            r_iter <= '0;
        end else if (i_cmd.rotate) begin
            r_iter <= r_iter + IW'(1);
        end
    end

    // corridor test: 2|y| < width in q20
    logic [W-1:0]  ay;
    logic [CW-1:0] lhs, rhs;
    logic          in_corr;
    assign ay      = r_y[W-1] ? W'(-r_y) : W'(r_y);
    assign lhs     = {ay, 1'b0};
    assign rhs     = CW'({r_width, FRAC_BITS'(0)});
    assign in_corr = (lhs < rhs);

    // rounded and saturated forward distance
    logic signed [W-1:0]     x_rnd, mm_full, mm_sat;
    logic signed [OUT_W-1:0] cand;
    assign x_rnd   = r_x + (W'(1) <<< (FRAC_BITS - 1));
    assign mm_full = x_rnd >>> FRAC_BITS;
    always_comb begin
        if (mm_full > W'((1 << FRAC_BITS) - 1)) begin
            mm_sat = W'((1 << FRAC_BITS) - 1);
        end else if (mm_full < -W'(1 << FRAC_BITS)) begin
            mm_sat = -W'(1 << FRAC_BITS);
        end else begin
            mm_sat = mm_full;
        end
    end
    assign cand = mm_sat[OUT_W-1:0];

    // running minimum, cleared when a scan is reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= OUT_W'(NONE_FOUND_MM);
        end else if (i_cmd.emit) begin
            r_min <= OUT_W'(NONE_FOUND_MM);
        end else if (i_cmd.update && in_corr && (cand < r_min)) begin
            r_min <= cand;
        end
    end

    // output data register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_min;
        end
    end
    assign o_nearest_forward_mm = r_out;

    // corridor width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_W'(WIDTH_RESET_MM);
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

endmodule

### rtl/corridor_obstacle_min_distance_top.sv
// ----------------------------------------------------------------------------
// corridor_obstacle_min_distance_top
// Nearest forward obstacle inside a corridor from a stream of laser points.
// ----------------------------------------------------------------------------
// Timing: after acceptance the sequencer runs load, the rotations of the
// shared iterative cordic rotator and the minimum update; a last point then
// goes to emit, which registers the result once the output is free. Flag
// points skip rotation and update. Points are taken one at a time.
// Reset: synchronous active low; clears the sequencer, the output valid, the
// running minimum to 1000000 and the corridor width to 400 mm.
module corridor_obstacle_min_distance_top #(
    parameter int CORDIC_STEPS = comd_pkg::COMD_CORDIC_STEPS,
    parameter int RANGE_BITS   = comd_pkg::COMD_RANGE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] range_mm, [32:16] bearing, [39:33] zero
    input  logic [comd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [20:0] nearest_forward_mm, [23:21] zero
    output logic [comd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // corridor width register
    input  logic                            i_cfg_we,
    input  logic [comd_pkg::WIDTH_W-1:0]    i_cfg_wdata
);
    import comd_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [OUT_W-1:0] nearest;

    comd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    comd_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .RANGE_BITS   (RANGE_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_range_mm           (s_axis_tdata[RANGE_IN_W-1:0]),
        .i_bearing            (s_axis_tdata[RANGE_IN_W+BEARING_W-1:RANGE_IN_W]),
        .i_scan_last          (s_axis_tlast),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .o_nearest_forward_mm (nearest)
    );

    // pad result to whole bytes
    assign m_axis_tdata = M_TDATA_W'(nearest);

endmodule

### rtl/comd_checker.sv
// ----------------------------------------------------------------------------
// comd_checker
// Port-level checks for the corridor nearest-obstacle block, bound to the
// top level.
// ----------------------------------------------------------------------------
module comd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [comd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import comd_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // nothing valid right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one point at a time: no acceptance in the cycle after a transaction
    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("point accepted while busy");

    // result never above the no-obstacle value, padding zero
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:OUT_W] == '0) &&
            (m_axis_tdata[OUT_W-1] ||
             (m_axis_tdata[OUT_W-2:0] <= (OUT_W-1)'(NONE_FOUND_MM))))
        else $error("result out of range");

endmodule

bind corridor_obstacle_min_distance_top comd_checker u_comd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
